// ===== hw/rtl/bspd_pkg.sv =====
// Shared constants and types for the byte-stuffed packet deframer.
// Holds the link symbol codes, result status codes and count widths.
// No dependencies.
package bspd_pkg;

  // Largest packet, in payload bytes, including the byte announced by an end marker.
  localparam int MAX_PAYLOAD = 1024;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD);
  localparam int IDX_W       = 10;
  localparam int IDX_EXT_W   = CNT_W + IDX_W;

  localparam logic [7:0] SYM_START   = 8'h7a;
  localparam logic [7:0] SYM_END     = 8'h7b;
  localparam logic [7:0] SYM_CHANNEL = 8'h7c;
  localparam logic [7:0] SYM_ESC     = 8'h7d;
  localparam logic [7:0] SYM_IDLE    = 8'h4a;
  localparam logic [7:0] SYM_ESC2    = 8'h4d;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] CHAN_ZERO   = 8'h00;

  typedef enum logic [2:0] {
    ST_START    = 3'd0,
    ST_DATA     = 3'd1,
    ST_LAST     = 3'd2,
    ST_CHAN_ERR = 3'd3,
    ST_SEQ_ERR  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

endpackage

// ===== hw/rtl/byte_stuffed_packet_deframer.sv =====
// Top level of the byte-stuffed packet deframer: framing state and result register.
// Depends on bspd_pkg for symbol codes, status codes and widths.
//
//   channel  direction  ports                                      handshake
//   in_      input      in_rx_byte                                 in_valid / in_stall
//   out_     output     out_status, out_data_byte, out_byte_index  out_valid / out_stall
//
// Each received byte is decoded in the cycle it is transferred, and its result (if any)
// is written into the output register at that same edge, so it is offered in the cycle
// after the transfer; one byte per cycle is sustained while no stalled result is held.
// The only storage between the channels is that single output register, so a stalled
// result holds in_stall high until the result is taken or the register is freed.
// rst_n is synchronous and active low; it puts the block into hunting for a start marker.
module byte_stuffed_packet_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  output logic [7:0]                 out_data_byte,
  output logic [bspd_pkg::IDX_W-1:0] out_byte_index
);

  logic                       in_packet_r, in_packet_nxt;
  logic                       end_seen_r, end_seen_nxt;
  logic                       chan_pend_r, chan_pend_nxt;
  logic                       esc_pend_r, esc_pend_nxt;
  logic [bspd_pkg::CNT_W-1:0] count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  bspd_pkg::status_t          status_r, res_status;
  logic [7:0]                 data_r, res_data;
  logic [bspd_pkg::IDX_W-1:0] index_r, res_index;

  logic                           in_xfer;
  logic                           out_xfer;
  logic                           res_valid;
  logic [7:0]                     unesc_byte;
  logic [bspd_pkg::IDX_EXT_W-1:0] index_ext;
  logic                           count_full;

  // A new byte may enter whenever the result register is empty or being drained.
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign out_xfer  = out_valid_r & ~out_stall;

  assign unesc_byte = esc_pend_r ? (in_rx_byte ^ bspd_pkg::ESC_XOR) : in_rx_byte;
  assign index_ext  = bspd_pkg::IDX_EXT_W'(count_r);
  assign count_full = (count_r == bspd_pkg::CNT_W'(bspd_pkg::MAX_PAYLOAD - 1));

  always_comb begin
    in_packet_nxt = in_packet_r;
    end_seen_nxt  = end_seen_r;
    chan_pend_nxt = chan_pend_r;
    esc_pend_nxt  = esc_pend_r;
    count_nxt     = count_r;
    res_valid     = 1'b0;
    res_status    = bspd_pkg::ST_DATA;
    res_data      = 8'h00;
    res_index     = '0;

    if (!in_packet_r && in_rx_byte != bspd_pkg::SYM_START) begin
      // Hunting: everything but a start marker is dropped.
    end else if (in_rx_byte == bspd_pkg::SYM_IDLE) begin
      // Idle bytes leave the state untouched.
    end else if (chan_pend_r) begin
      chan_pend_nxt = 1'b0;
      if (in_rx_byte != bspd_pkg::CHAN_ZERO) begin
        in_packet_nxt = 1'b0;
        end_seen_nxt  = 1'b0;
        esc_pend_nxt  = 1'b0;
        count_nxt     = '0;
        res_valid     = 1'b1;
        res_status    = bspd_pkg::ST_CHAN_ERR;
      end
    end else begin
      case (in_rx_byte)
        bspd_pkg::SYM_START: begin
          in_packet_nxt = 1'b1;
          end_seen_nxt  = 1'b0;
          esc_pend_nxt  = 1'b0;
          count_nxt     = '0;
          res_valid     = 1'b1;
          res_status    = bspd_pkg::ST_START;
        end
        bspd_pkg::SYM_END, bspd_pkg::SYM_CHANNEL: begin
          if (esc_pend_r || end_seen_r) begin
            in_packet_nxt = 1'b0;
            end_seen_nxt  = 1'b0;
            esc_pend_nxt  = 1'b0;
            count_nxt     = '0;
            res_valid     = 1'b1;
            res_status    = bspd_pkg::ST_SEQ_ERR;
          end else if (in_rx_byte == bspd_pkg::SYM_END) begin
            end_seen_nxt = 1'b1;
          end else begin
            chan_pend_nxt = 1'b1;
          end
        end
        bspd_pkg::SYM_ESC, bspd_pkg::SYM_ESC2: begin
          if (esc_pend_r) begin
            in_packet_nxt = 1'b0;
            end_seen_nxt  = 1'b0;
            esc_pend_nxt  = 1'b0;
            count_nxt     = '0;
            res_valid     = 1'b1;
            res_status    = bspd_pkg::ST_SEQ_ERR;
          end else begin
            esc_pend_nxt = 1'b1;
          end
        end
        default: begin
          esc_pend_nxt = 1'b0;
          res_valid    = 1'b1;
          if (end_seen_r) begin
            in_packet_nxt = 1'b0;
            end_seen_nxt  = 1'b0;
            count_nxt     = '0;
            res_status    = bspd_pkg::ST_LAST;
            res_data      = unesc_byte;
            res_index     = index_ext[bspd_pkg::IDX_W-1:0];
          end else if (count_full) begin
            // The last place is reserved for a byte announced by an end marker.
            in_packet_nxt = 1'b0;
            count_nxt     = '0;
            res_status    = bspd_pkg::ST_OVERFLOW;
          end else begin
            count_nxt  = count_r + 1'b1;
            res_status = bspd_pkg::ST_DATA;
            res_data   = unesc_byte;
            res_index  = index_ext[bspd_pkg::IDX_W-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = res_valid;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      end_seen_r  <= 1'b0;
      chan_pend_r <= 1'b0;
      esc_pend_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        in_packet_r <= in_packet_nxt;
        end_seen_r  <= end_seen_nxt;
        chan_pend_r <= chan_pend_nxt;
        esc_pend_r  <= esc_pend_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      status_r <= res_status;
      data_r   <= res_data;
      index_r  <= res_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_data_byte  = data_r;
  assign out_byte_index = index_r;

  // A channel number is only awaited with no escape or end marker outstanding.
  a_chan_flags: assert property (@(posedge clk) disable iff (!rst_n)
    chan_pend_r |-> !(esc_pend_r || end_seen_r))
    else $error("channel pending together with escape or end flag");

  // Every error or last-byte result leaves the block hunting with a cleared count.
  a_hunt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res_valid && (res_status == bspd_pkg::ST_LAST ||
      res_status == bspd_pkg::ST_CHAN_ERR || res_status == bspd_pkg::ST_SEQ_ERR ||
      res_status == bspd_pkg::ST_OVERFLOW))
    |=> (!in_packet_r && count_r == '0 && !end_seen_r && !esc_pend_r))
    else $error("block not hunting after packet end or error");

  // A start result opens a fresh packet.
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res_valid && res_status == bspd_pkg::ST_START)
    |=> (in_packet_r && count_r == '0))
    else $error("start marker did not open a packet");

  // Only payload results carry a data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !(status_r == bspd_pkg::ST_DATA || status_r == bspd_pkg::ST_LAST))
    |-> (data_r == 8'h00 && index_r == '0))
    else $error("non-payload result carries data");

endmodule
